FILE: sv/rgis_pkg.sv
package rgis_pkg;

   // Tile edge in pixels; must be a power of two
   localparam int TILE_PIXELS  = 64;
   // Tile edge in Q.8 units is 2**TILE_SHIFT
   localparam int TILE_SHIFT   = $clog2(TILE_PIXELS) + 8;
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = 5;
   localparam int LANES        = 4;

   localparam int POS_W  = 24;
   localparam int ANG_W  = 16;
   localparam int GRID_W = POS_W + 1;
   localparam int DH_W   = TILE_SHIFT + 2;
   localparam int CS_W   = 33;
   localparam int Z_W    = 25;
   localparam int QUO_W  = 33;
   localparam int NUM_W  = TILE_SHIFT + 32;
   localparam int PROD_W = NUM_W + 1;

   localparam logic [GRID_W-1:0]      TILE_Q     = GRID_W'(1) << TILE_SHIFT;
   localparam logic signed [CS_W-1:0] CORDIC_ONE = CS_W'(1) <<< 30;
   localparam logic signed [31:0]     S32_MAX    = 32'sh7fff_ffff;
   localparam logic signed [31:0]     S32_MIN    = 32'sh8000_0000;
   localparam logic [QUO_W-1:0]       POS_LIMIT  = QUO_W'(64'h7fff_ffff);
   localparam logic [QUO_W-1:0]       NEG_LIMIT  = QUO_W'(64'h8000_0000);

   typedef struct packed {
      logic [POS_W-1:0] player_x;
      logic [POS_W-1:0] player_y;
      logic [ANG_W-1:0] heading;
   } req_type;

   typedef struct packed {
      logic               facing_down;
      logic               facing_right;
      logic signed [31:0] horz_x;
      logic signed [31:0] horz_y;
      logic signed [31:0] horz_xstep;
      logic signed [31:0] horz_ystep;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_xstep;
      logic signed [31:0] vert_ystep;
      logic               clipped;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]       px;
      logic [POS_W-1:0]       py;
      logic                   down;
      logic                   right;
      logic [GRID_W-1:0]      hy;
      logic [GRID_W-1:0]      vx;
      logic signed [DH_W-1:0] dh;
      logic signed [DH_W-1:0] dv;
      logic [1:0]             quad;
      logic                   r_zero;
   } ctx_type;

   typedef struct packed {
      logic signed [CS_W-1:0] x;
      logic signed [CS_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      ctx_type                ctx;
   } cordic_type;

   typedef struct packed {
      logic [QUO_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic [QUO_W-1:0] den;
   } lane_type;

   typedef struct packed {
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic              down;
      logic              right;
      logic [GRID_W-1:0] hy;
      logic [GRID_W-1:0] vx;
      logic              s_zero;
      logic              c_zero;
      logic [LANES-1:0]  neg;
      logic [LANES-1:0]  ov;
   } div_info_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      div_info_type         info;
   } div_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } sat_type;

   // Arctangent of 2**-i in 2**24 units per turn
   function automatic logic signed [Z_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = Z_W'(2097152);
         5'd1:  v = Z_W'(1238021);
         5'd2:  v = Z_W'(654136);
         5'd3:  v = Z_W'(332050);
         5'd4:  v = Z_W'(166669);
         5'd5:  v = Z_W'(83416);
         5'd6:  v = Z_W'(41718);
         5'd7:  v = Z_W'(20860);
         5'd8:  v = Z_W'(10430);
         5'd9:  v = Z_W'(5215);
         5'd10: v = Z_W'(2608);
         5'd11: v = Z_W'(1304);
         5'd12: v = Z_W'(652);
         5'd13: v = Z_W'(326);
         5'd14: v = Z_W'(163);
         5'd15: v = Z_W'(81);
         5'd16: v = Z_W'(41);
         5'd17: v = Z_W'(20);
         5'd18: v = Z_W'(10);
         5'd19: v = Z_W'(5);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/rgis_cordic_cell.sv
module rgis_cordic_cell
   import rgis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [STEP_W-1:0] step_idx,
   input  logic              in_valid,
   output logic              in_ready,
   input  cordic_type        in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cordic_type        out_data
);

   logic                   valid_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [CS_W-1:0] dx;
   logic signed [CS_W-1:0] dy;

   assign in_ready = !valid_ff || out_ready;

   // one rotation step, direction from the sign of the residual angle
   always_comb begin
      dx      = in_data.y >>> step_idx;
      dy      = in_data.x >>> step_idx;
      data_in = in_data;
      if (!in_data.z[Z_W-1]) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - atan_turn(step_idx);
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + atan_turn(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/rgis_div_cell.sv
module rgis_div_cell
   import rgis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic             valid_ff;
   div_type          data_ff;
   div_type          data_in;
   logic [QUO_W:0]   trial;

   assign in_ready = !valid_ff || out_ready;

   // one restoring quotient bit per lane
   always_comb begin
      trial   = '0;
      data_in = in_data;
      for (int i = 0; i < LANES; i++) begin
         trial = {in_data.lane[i].rem, in_data.lane[i].low[QUO_W-1]};
         data_in.lane[i].low = {in_data.lane[i].low[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, in_data.lane[i].den}) begin
            data_in.lane[i].rem = QUO_W'(trial - {1'b0, in_data.lane[i].den});
            data_in.lane[i].quo = {in_data.lane[i].quo[QUO_W-2:0], 1'b1};
         end else begin
            data_in.lane[i].rem = trial[QUO_W-1:0];
            data_in.lane[i].quo = {in_data.lane[i].quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/ray_grid_intercept_setup.sv
// Channel   Ports                         Direction  Moves
// request   req_valid req_stall req_data  in         player position and ray angle
// response  rsp_valid rsp_stall rsp_data  out        intercepts, steps, facing, clip flag
//
// One request per cycle sustained while rsp_stall is low; stages: 20 CORDIC cells, quadrant map,
// product stage, divider set-up, 33 divider cells (one quotient bit each), output register.
// Every stage has its own valid bit, so bubbles collapse and requests keep entering while
// a response is held by rsp_stall, until the pipeline is full.
// Synchronous active-high reset clears the valid bits only.
module ray_grid_intercept_setup
   import rgis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic signed [CS_W-1:0] c;
      logic signed [CS_W-1:0] s;
      ctx_type                ctx;
   } cs_type;

   typedef struct packed {
      logic [LANES-1:0][PROD_W-1:0] prod;
      logic signed [CS_W-1:0]       c;
      logic signed [CS_W-1:0]       s;
      ctx_type                      ctx;
   } prod_type;

   // base position (px or py) + signed quotient, saturated to 32 bits
   function automatic sat_type sat_add(input logic [POS_W-1:0] base,
                                       input logic [QUO_W-1:0] mag,
                                       input logic neg, input logic ov);
      logic signed [QUO_W+1:0] q;
      logic signed [QUO_W+1:0] sum;
      logic [QUO_W+1-31:0]     hi;
      sat_type                 r;
      q   = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      sum = q + $signed((QUO_W+2)'(base));
      hi  = sum[QUO_W+1:31];
      r.clip  = 1'b0;
      r.value = sum[31:0];
      if (ov) begin
         r.clip  = 1'b1;
         r.value = neg ? S32_MIN : S32_MAX;
      end else if (hi != '0 && hi != '1) begin
         r.clip  = 1'b1;
         r.value = sum[QUO_W+1] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   // step magnitude with the sign forced to the facing direction
   function automatic sat_type sat_step(input logic [QUO_W-1:0] mag,
                                        input logic ov, input logic pos);
      sat_type r;
      r.clip  = 1'b0;
      r.value = pos ? 32'(mag) : 32'(~mag + QUO_W'(1));
      if (pos && (ov || mag > POS_LIMIT)) begin
         r.clip  = 1'b1;
         r.value = S32_MAX;
      end else if (!pos && (ov || mag > NEG_LIMIT)) begin
         r.clip  = 1'b1;
         r.value = S32_MIN;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- entry
   cordic_type               cor_data  [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]    cor_valid;
   logic [CORDIC_STEPS:0]    cor_ready;
   logic [POS_W-1:0]         py_floor;
   logic [POS_W-1:0]         px_floor;
   logic                     ent_down;
   logic                     ent_right;
   logic [GRID_W-1:0]        ent_hy;
   logic [GRID_W-1:0]        ent_vx;

   assign ent_down  = (req_data.heading != '0) && !req_data.heading[ANG_W-1];
   assign ent_right = (req_data.heading < ANG_W'(16384)) ||
                      (req_data.heading > ANG_W'(49152));
   assign py_floor  = {req_data.player_y[POS_W-1:TILE_SHIFT], TILE_SHIFT'(0)};
   assign px_floor  = {req_data.player_x[POS_W-1:TILE_SHIFT], TILE_SHIFT'(0)};
   assign ent_hy    = GRID_W'(py_floor) + (ent_down  ? TILE_Q : '0);
   assign ent_vx    = GRID_W'(px_floor) + (ent_right ? TILE_Q : '0);

   always_comb begin
      cor_data[0].x          = CORDIC_ONE;
      cor_data[0].y          = '0;
      cor_data[0].z          = Z_W'({req_data.heading[13:0], 8'b0});
      cor_data[0].ctx.px     = req_data.player_x;
      cor_data[0].ctx.py     = req_data.player_y;
      cor_data[0].ctx.down   = ent_down;
      cor_data[0].ctx.right  = ent_right;
      cor_data[0].ctx.hy     = ent_hy;
      cor_data[0].ctx.vx     = ent_vx;
      // distance to the grid line lies within one tile either way
      cor_data[0].ctx.dh     = DH_W'({1'b0, ent_hy} - {2'b00, req_data.player_y});
      cor_data[0].ctx.dv     = DH_W'({1'b0, ent_vx} - {2'b00, req_data.player_x});
      cor_data[0].ctx.quad   = req_data.heading[15:14];
      cor_data[0].ctx.r_zero = (req_data.heading[13:0] == '0);
   end

   assign cor_valid[0] = req_valid;
   assign req_stall    = !cor_ready[0];

   // ---------------------------------------------------------------- CORDIC chain
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      rgis_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(k)),
         .in_valid  (cor_valid[k]),
         .in_ready  (cor_ready[k]),
         .in_data   (cor_data[k]),
         .out_valid (cor_valid[k+1]),
         .out_ready (cor_ready[k+1]),
         .out_data  (cor_data[k+1])
      );
   end

   // ---------------------------------------------------------------- quadrant map
   logic                   qa_valid_ff;
   cs_type                 qa_ff;
   cs_type                 qa_in;
   logic                   qa_ready;
   logic signed [CS_W-1:0] cx;
   logic signed [CS_W-1:0] sy;
   logic                   pr_ready;

   assign qa_ready = !qa_valid_ff || pr_ready;
   assign cor_ready[CORDIC_STEPS] = qa_ready;

   always_comb begin
      // zero residual angle takes the exact unrotated vector in place of the CORDIC output
      cx = cor_data[CORDIC_STEPS].ctx.r_zero ? CORDIC_ONE : cor_data[CORDIC_STEPS].x;
      sy = cor_data[CORDIC_STEPS].ctx.r_zero ? '0 : cor_data[CORDIC_STEPS].y;
      qa_in.ctx = cor_data[CORDIC_STEPS].ctx;
      case (cor_data[CORDIC_STEPS].ctx.quad)
         2'd0: begin
            qa_in.c = cx;
            qa_in.s = sy;
         end
         2'd1: begin
            qa_in.c = -sy;
            qa_in.s = cx;
         end
         2'd2: begin
            qa_in.c = -cx;
            qa_in.s = -sy;
         end
         default: begin
            qa_in.c = sy;
            qa_in.s = -cx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_valid_ff <= 1'b0;
      end else if (qa_ready) begin
         qa_valid_ff <= cor_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (qa_ready && cor_valid[CORDIC_STEPS]) begin
         qa_ff <= qa_in;
      end
   end

   // ---------------------------------------------------------------- products
   logic                          pr_valid_ff;
   prod_type                      pr_ff;
   prod_type                      pr_in;
   logic signed [DH_W+CS_W-1:0]   mul_h;
   logic signed [DH_W+CS_W-1:0]   mul_v;
   logic                          dp_ready;

   assign pr_ready = !pr_valid_ff || dp_ready;

   always_comb begin
      mul_h       = qa_ff.ctx.dh * qa_ff.c;
      mul_v       = qa_ff.ctx.dv * qa_ff.s;
      pr_in.c     = qa_ff.c;
      pr_in.s     = qa_ff.s;
      pr_in.ctx   = qa_ff.ctx;
      pr_in.prod[0] = PROD_W'(mul_h);
      pr_in.prod[1] = PROD_W'(qa_ff.c) <<< TILE_SHIFT;
      pr_in.prod[2] = PROD_W'(mul_v);
      pr_in.prod[3] = PROD_W'(qa_ff.s) <<< TILE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (pr_ready) begin
         pr_valid_ff <= qa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pr_ready && qa_valid_ff) begin
         pr_ff <= pr_in;
      end
   end

   // ---------------------------------------------------------------- divider set-up
   // lanes: 0 dh*c/s, 1 T*c/s, 2 dv*s/c, 3 T*s/c
   div_type                 div_data  [QUO_W+1];
   logic [QUO_W:0]          div_valid;
   logic [QUO_W:0]          div_ready;
   logic                    dp_valid_ff;
   div_type                 dp_ff;
   div_type                 dp_in;
   logic [PROD_W-1:0]       pmag;
   logic [NUM_W-1:0]        num_mag;
   logic signed [CS_W-1:0]  den;
   logic [CS_W-1:0]         den_mag;

   assign dp_ready = !dp_valid_ff || div_ready[0];

   always_comb begin
      pmag    = '0;
      num_mag = '0;
      den     = '0;
      den_mag = '0;
      dp_in.info.px     = pr_ff.ctx.px;
      dp_in.info.py     = pr_ff.ctx.py;
      dp_in.info.down   = pr_ff.ctx.down;
      dp_in.info.right  = pr_ff.ctx.right;
      dp_in.info.hy     = pr_ff.ctx.hy;
      dp_in.info.vx     = pr_ff.ctx.vx;
      dp_in.info.s_zero = (pr_ff.s == '0);
      dp_in.info.c_zero = (pr_ff.c == '0);
      for (int i = 0; i < LANES; i++) begin
         den     = (i < 2) ? pr_ff.s : pr_ff.c;
         pmag    = pr_ff.prod[i][PROD_W-1] ? (~pr_ff.prod[i] + PROD_W'(1)) : pr_ff.prod[i];
         num_mag = pmag[NUM_W-1:0];
         den_mag = den[CS_W-1] ? (~den + CS_W'(1)) : den;
         dp_in.info.neg[i]   = pr_ff.prod[i][PROD_W-1] ^ den[CS_W-1];
         // quotient would need more than QUO_W bits
         dp_in.info.ov[i]    = QUO_W'(num_mag[NUM_W-1:QUO_W]) >= QUO_W'(den_mag);
         dp_in.lane[i].rem   = QUO_W'(num_mag[NUM_W-1:QUO_W]);
         dp_in.lane[i].low   = num_mag[QUO_W-1:0];
         dp_in.lane[i].quo   = '0;
         dp_in.lane[i].den   = QUO_W'(den_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_valid_ff <= 1'b0;
      end else if (dp_ready) begin
         dp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_ready && pr_valid_ff) begin
         dp_ff <= dp_in;
      end
   end

   assign div_valid[0] = dp_valid_ff;
   assign div_data[0]  = dp_ff;

   // ---------------------------------------------------------------- divider chain
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      rgis_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   // ---------------------------------------------------------------- saturation, output
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         out_ready;
   div_info_type fin;
   sat_type      hx_r;
   sat_type      hxs_r;
   sat_type      vy_r;
   sat_type      vys_r;

   assign out_ready        = !rsp_valid_ff || !rsp_stall;
   assign div_ready[QUO_W] = out_ready;
   assign fin              = div_data[QUO_W].info;

   always_comb begin
      hx_r  = sat_add(fin.px, div_data[QUO_W].lane[0].quo, fin.neg[0], fin.ov[0]);
      hxs_r = sat_step(div_data[QUO_W].lane[1].quo, fin.ov[1], fin.right);
      vy_r  = sat_add(fin.py, div_data[QUO_W].lane[2].quo, fin.neg[2], fin.ov[2]);
      vys_r = sat_step(div_data[QUO_W].lane[3].quo, fin.ov[3], fin.down);
      // horizontal ray: no horizontal crossing
      if (fin.s_zero) begin
         hx_r.clip   = 1'b1;
         hx_r.value  = fin.right ? S32_MAX : S32_MIN;
         hxs_r       = hx_r;
      end
      // vertical ray: no vertical crossing
      if (fin.c_zero) begin
         vy_r.clip   = 1'b1;
         vy_r.value  = fin.down ? S32_MAX : S32_MIN;
         vys_r       = vy_r;
      end
      rsp_in.facing_down  = fin.down;
      rsp_in.facing_right = fin.right;
      rsp_in.horz_x       = hx_r.value;
      rsp_in.horz_y       = 32'(fin.hy);
      rsp_in.horz_xstep   = hxs_r.value;
      rsp_in.horz_ystep   = fin.down ? 32'(TILE_Q) : -32'(TILE_Q);
      rsp_in.vert_x       = 32'(fin.vx);
      rsp_in.vert_y       = vy_r.value;
      rsp_in.vert_xstep   = fin.right ? 32'(TILE_Q) : -32'(TILE_Q);
      rsp_in.vert_ystep   = vys_r.value;
      rsp_in.clipped      = hx_r.clip | hxs_r.clip | vy_r.clip | vys_r.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[QUO_W]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
